// ----- hdl/pbd_pkg.sv -----
// Shared types, constants and the arctangent table for the planar bearing pipeline.
package pbd_pkg;

  localparam int LAT_W     = 28;
  localparam int LON_W     = 29;
  localparam int BEARING_W = 25;
  localparam int DX_W      = LON_W + 1;
  localparam int DY_W      = LAT_W + 1;
  localparam int DATA_W    = 64;
  localparam int ANG_W     = 32;
  localparam int PRESCALE  = 30;
  localparam int TABLE_FRAC = 24;
  localparam int TABLE_LEN = 32;

  // 90 degrees in table units
  localparam logic signed [ANG_W-1:0] ZMAX = 32'sd1509949440;

  // atan(2^-i) in degrees, units of 2^-24, rounded to nearest
  localparam logic signed [ANG_W-1:0] ATAN_DEG [TABLE_LEN] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
    32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
    32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
    32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
    32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
    32'sd917,       32'sd458,       32'sd229,       32'sd115,
    32'sd57,        32'sd29,        32'sd14,        32'sd7,
    32'sd4,         32'sd2,         32'sd1,         32'sd0
  };

  // fixed answers for axis-aligned vectors
  typedef enum logic [1:0] {
    DIR_N,
    DIR_E,
    DIR_S,
    DIR_W
  } dir_t;

  typedef struct packed {
    logic special;
    dir_t dir;
    logic dx_neg;
    logic dy_neg;
  } side_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [ANG_W-1:0]  z;
  } cordic_t;

endpackage

// ----- hdl/pbd_prep.sv -----
// Front end: coordinate differences, axis cases, quadrant and scaled magnitudes.
module pbd_prep import pbd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [LAT_W-1:0] start_lat,
  input  logic signed [LON_W-1:0] start_lon,
  input  logic signed [LAT_W-1:0] end_lat,
  input  logic signed [LON_W-1:0] end_lon,
  output logic                    out_vld,
  output side_t                   side,
  output cordic_t                 cd
);

  logic                   vld1;
  logic signed [DX_W-1:0] dx;
  logic signed [DY_W-1:0] dy;
  logic [DX_W-1:0]        mag_x;
  logic [DY_W-1:0]        mag_y;
  side_t                  side_next;
  cordic_t                cd_next;

  always_comb begin
    mag_x = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
    mag_y = dy[DY_W-1] ? DY_W'(-dy) : DY_W'(dy);
    side_next.dx_neg  = dx[DX_W-1];
    side_next.dy_neg  = dy[DY_W-1];
    side_next.special = (dx == '0) || (dy == '0);
    if (dx == '0) begin
      side_next.dir = (!dy[DY_W-1] && dy != '0) ? DIR_N : DIR_S;
    end else begin
      side_next.dir = dx[DX_W-1] ? DIR_W : DIR_E;
    end
    cd_next.x = signed'(DATA_W'(mag_x) << PRESCALE);
    cd_next.y = signed'(DATA_W'(mag_y) << PRESCALE);
    cd_next.z = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx   <= DX_W'(end_lon) - DX_W'(start_lon);
      dy   <= DY_W'(end_lat) - DY_W'(start_lat);
      side <= side_next;
      cd   <= cd_next;
    end
  end

endmodule

// ----- hdl/pbd_cell.sv -----
// One vectoring rotation step; the chain of these forms the angle unit.
module pbd_cell import pbd_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_vld,
  input  side_t   in_side,
  input  cordic_t in_cd,
  output logic    out_vld,
  output side_t   out_side,
  output cordic_t out_cd
);

  localparam logic signed [ANG_W-1:0] ANGLE = ATAN_DEG[STEP];

  logic signed [DATA_W-1:0] xs;
  logic signed [DATA_W-1:0] ys;
  cordic_t                  cd_next;

  always_comb begin
    xs = in_cd.x >>> STEP;
    ys = in_cd.y >>> STEP;
    // rotate toward the x axis
    if (!in_cd.y[DATA_W-1]) begin
      cd_next.x = in_cd.x + ys;
      cd_next.y = in_cd.y - xs;
      cd_next.z = in_cd.z + ANGLE;
    end else begin
      cd_next.x = in_cd.x - ys;
      cd_next.y = in_cd.y + xs;
      cd_next.z = in_cd.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_cd   <= cd_next;
    end
  end

endmodule

// ----- hdl/pbd_finish.sv -----
// Back end: angle clamp and rounding, quadrant mapping, output register.
module pbd_finish import pbd_pkg::*; #(
  parameter int OUT_FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  side_t                in_side,
  input  cordic_t              in_cd,
  output logic                 out_valid,
  output logic [BEARING_W-1:0] bearing
);

  localparam int SHIFT = TABLE_FRAC - OUT_FRACTION_BITS;
  localparam int AW    = OUT_FRACTION_BITS + 7;
  localparam int BW    = OUT_FRACTION_BITS + 10;
  localparam logic [BW-1:0] D90  = BW'(90) << OUT_FRACTION_BITS;
  localparam logic [BW-1:0] D180 = BW'(180) << OUT_FRACTION_BITS;
  localparam logic [BW-1:0] D270 = BW'(270) << OUT_FRACTION_BITS;
  localparam logic [BW-1:0] D360 = BW'(360) << OUT_FRACTION_BITS;

  logic [ANG_W-1:0] z_clamp;
  logic [AW-1:0]    a_next;
  logic [AW-1:0]    a;
  side_t            side;
  logic             vld_a;
  logic [BW-1:0]    b_next;

  always_comb begin
    if (in_cd.z[ANG_W-1]) begin
      z_clamp = '0;
    end else if (in_cd.z > ZMAX) begin
      z_clamp = ZMAX;
    end else begin
      z_clamp = in_cd.z;
    end
  end

  generate
    if (SHIFT > 0) begin : g_round
      assign a_next = AW'((z_clamp + (ANG_W'(1) << (SHIFT - 1))) >> SHIFT);
    end else begin : g_exact
      assign a_next = AW'(z_clamp);
    end
  endgenerate

  always_comb begin
    if (side.special) begin
      case (side.dir)
        DIR_N:   b_next = '0;
        DIR_E:   b_next = D90;
        DIR_S:   b_next = D180;
        default: b_next = D270;
      endcase
    end else begin
      case ({side.dx_neg, side.dy_neg})
        2'b10:   b_next = D270 + BW'(a);
        2'b11:   b_next = D270 - BW'(a);
        2'b01:   b_next = D90 + BW'(a);
        default: b_next = D90 - BW'(a);
      endcase
      // a full circle wraps to north
      if (b_next >= D360) begin
        b_next = b_next - D360;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_a     <= in_vld;
      out_valid <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a       <= a_next;
      side    <= in_side;
      bearing <= BEARING_W'(b_next);
    end
  end

endmodule

// ----- hdl/planar_bearing_degrees_top.sv -----
// Top level of the planar bearing pipeline.
//
// Input channel: start_lat/start_lon/end_lat/end_lon with in_valid/in_stall.
// A transfer happens on a rising edge with in_valid high and in_stall low.
// Output channel: bearing with out_valid/out_stall, same rule.
// bearing is clockwise from north in units of 2^-OUT_FRACTION_BITS degree.
//
// The pipeline has two front-end stages, one rotation cell per iteration and two
// back-end stages, the last being the output register. Throughput: one item
// per cycle while out_stall does not freeze the pipeline; the chain of
// rotation cells holds one item in each stage.
//
// The whole pipeline advances together. While the output register holds an
// item and out_stall is high, every stage freezes and in_stall is raised;
// nothing is dropped and the output payload holds steady.
// Reset (rst, synchronous) clears all stage valid bits; no item is in
// flight afterward and in_stall is low.
module planar_bearing_degrees_top import pbd_pkg::*; #(
  parameter int ANGLE_ITERATIONS  = 20,
  parameter int OUT_FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [LAT_W-1:0] start_lat,
  input  logic signed [LON_W-1:0] start_lon,
  input  logic signed [LAT_W-1:0] end_lat,
  input  logic signed [LON_W-1:0] end_lon,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [BEARING_W-1:0]    bearing
);

  logic    en;
  logic    vld  [ANGLE_ITERATIONS+1];
  side_t   side [ANGLE_ITERATIONS+1];
  cordic_t cd   [ANGLE_ITERATIONS+1];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  pbd_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (in_valid),
    .start_lat (start_lat),
    .start_lon (start_lon),
    .end_lat   (end_lat),
    .end_lon   (end_lon),
    .out_vld   (vld[0]),
    .side      (side[0]),
    .cd        (cd[0])
  );

  generate
    for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cell
      pbd_cell #(.STEP(i)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .in_vld   (vld[i]),
        .in_side  (side[i]),
        .in_cd    (cd[i]),
        .out_vld  (vld[i+1]),
        .out_side (side[i+1]),
        .out_cd   (cd[i+1])
      );
    end
  endgenerate

  pbd_finish #(.OUT_FRACTION_BITS(OUT_FRACTION_BITS)) u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (vld[ANGLE_ITERATIONS]),
    .in_side   (side[ANGLE_ITERATIONS]),
    .in_cd     (cd[ANGLE_ITERATIONS]),
    .out_valid (out_valid),
    .bearing   (bearing)
  );

endmodule

// ----- hdl/pbd_checker.sv -----
// Port-level checks for the planar bearing top level, and their bind.
module pbd_checker import pbd_pkg::*; #(
  parameter int OUT_FRACTION_BITS = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [BEARING_W-1:0] bearing
);

  localparam int LIMIT_W = OUT_FRACTION_BITS + 10;
  localparam logic [LIMIT_W-1:0] LIMIT = LIMIT_W'(360) << OUT_FRACTION_BITS;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(bearing))
    else $error("bearing changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while the output is blocked");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  generate
    if (OUT_FRACTION_BITS + 9 <= BEARING_W) begin : g_range
      a_range: assert property (@(posedge clk) disable iff (rst)
        out_valid |-> LIMIT_W'(bearing) < LIMIT)
        else $error("bearing at or beyond a full circle");
    end
  endgenerate

endmodule

bind planar_bearing_degrees_top pbd_checker #(.OUT_FRACTION_BITS(OUT_FRACTION_BITS)) u_pbd_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .bearing   (bearing)
);
